>>> hw/rtl/tone_band_bar_meter_defines.svh
// assertion macros for the tone band bar meter
// no dependencies; included by the files that carry assertions
`ifndef TONE_BAND_BAR_METER_DEFINES_SVH
`define TONE_BAND_BAR_METER_DEFINES_SVH

// consequent checked in the same cycle as the antecedent
`define TBBM_ASSERT_SAME(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// consequent checked in the cycle after the antecedent
`define TBBM_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> hw/rtl/tbbm_pkg.sv
// shared widths, register codes, reset values and the decay function
// used by all modules of the tone band bar meter; no dependencies
package tbbm_pkg;

   localparam int DIV_W  = 8;
   localparam int CTR_W  = 15;
   localparam int FS_W   = 6;
   localparam int PER_W  = 16;
   localparam int LVL_W  = 6;
   localparam int DEN_W  = DIV_W + PER_W;
   localparam int NB_W   = 24;
   localparam int PROD_W = FS_W + NB_W;
   localparam int BAR_CNT = 4;
   localparam int BAR_IDX_W = 2;

   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 15;

   localparam logic [CSR_IDX_W-1:0] CSR_CLOCK_DIVIDER = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_CENTER_0      = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_CENTER_1      = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_CENTER_2      = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_CENTER_3      = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_FULL_SCALE    = 3'd5;

   localparam logic [DIV_W-1:0] RST_CLOCK_DIVIDER = 8'd35;
   localparam logic [CTR_W-1:0] RST_CENTER_0      = 15'd63;
   localparam logic [CTR_W-1:0] RST_CENTER_1      = 15'd160;
   localparam logic [CTR_W-1:0] RST_CENTER_2      = 15'd400;
   localparam logic [CTR_W-1:0] RST_CENTER_3      = 15'd1200;
   localparam logic [FS_W-1:0]  RST_FULL_SCALE    = 6'd44;

   // floor(4*x/5) as x*205 >> 8, exact for six-bit x
   function automatic logic [LVL_W-1:0] decay_level(input logic [LVL_W-1:0] lvl);
      logic [LVL_W+7:0] prod;
      prod = {8'b0, lvl} * (LVL_W+8)'(205);
      return prod[LVL_W+7:8];
   endfunction

endpackage

>>> hw/rtl/tbbm_freq_div.sv
// bit-serial restoring divider: frequency = REF_CLOCK_HZ*256 / divisor
// one quotient bit per cycle; uses tbbm_pkg
module tbbm_freq_div #(
   parameter int unsigned REF_CLOCK_HZ = 125000000,
   localparam longint unsigned DIVIDEND = 64'(REF_CLOCK_HZ) << 8,
   localparam int FW = $clog2(DIVIDEND + 1)
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   input  logic [tbbm_pkg::DEN_W-1:0] divisor,
   output logic [FW-1:0]             quotient,
   output logic                      done
);

   localparam int CNT_W = $clog2(FW);

   logic [tbbm_pkg::DEN_W-1:0] rem_ff, rem_in;
   logic [FW-1:0]              quo_ff, quo_in;
   logic [CNT_W-1:0]           cnt_ff, cnt_in;
   logic                       run_ff, run_in;
   logic                       done_ff, done_in;
   logic [tbbm_pkg::DEN_W:0]   trial;
   logic                       fits;

   assign trial = {rem_ff, quo_ff[FW-1]};
   assign fits  = trial >= {1'b0, divisor};

   always_comb begin
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      cnt_in  = cnt_ff;
      run_in  = run_ff;
      done_in = 1'b0;
      if (start) begin
         rem_in = '0;
         quo_in = FW'(DIVIDEND);
         cnt_in = '0;
         run_in = 1'b1;
      end else if (run_ff) begin
         // dividend bits leave at the top while quotient bits enter at the bottom
         rem_in = fits ? tbbm_pkg::DEN_W'(trial - {1'b0, divisor})
                       : trial[tbbm_pkg::DEN_W-1:0];
         quo_in = {quo_ff[FW-2:0], fits};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CNT_W'(FW - 1)) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      cnt_ff <= cnt_in;
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
      end
   end

   assign quotient = quo_ff;
   assign done     = done_ff;

endmodule

>>> hw/rtl/tbbm_level_div.sv
// serial divider for one bar level: floor(product / den), six quotient bits
// one bit per cycle with a shifting divisor; uses tbbm_pkg
module tbbm_level_div (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   input  logic [tbbm_pkg::PROD_W-1:0] product,
   input  logic [tbbm_pkg::NB_W-1:0]   den,
   output logic [tbbm_pkg::LVL_W-1:0]  level,
   output logic                       done
);

   localparam int PW    = tbbm_pkg::PROD_W;
   localparam int LW    = tbbm_pkg::LVL_W;
   localparam int CNT_W = $clog2(LW);

   logic [PW-1:0]    rem_ff, rem_in;
   logic [PW-1:0]    dsh_ff, dsh_in;
   logic [LW-1:0]    q_ff, q_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             run_ff, run_in;
   logic             done_ff, done_in;
   logic             fits;

   assign fits = rem_ff >= dsh_ff;

   always_comb begin
      rem_in  = rem_ff;
      dsh_in  = dsh_ff;
      q_in    = q_ff;
      cnt_in  = cnt_ff;
      run_in  = run_ff;
      done_in = 1'b0;
      if (start) begin
         rem_in = product;
         // divisor aligned to the top quotient bit
         dsh_in = PW'({den, (LW - 1)'(0)});
         q_in   = '0;
         cnt_in = '0;
         run_in = 1'b1;
      end else if (run_ff) begin
         rem_in = fits ? rem_ff - dsh_ff : rem_ff;
         dsh_in = dsh_ff >> 1;
         q_in   = {q_ff[LW-2:0], fits};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CNT_W'(LW - 1)) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      dsh_ff <= dsh_in;
      q_ff   <= q_in;
      cnt_ff <= cnt_in;
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
      end
   end

   assign level = q_ff;
   assign done  = done_ff;

endmodule

>>> hw/rtl/tone_band_bar_meter.sv
// Four-bar peak-hold spectrum meter driven by tone periods. One request is
// taken at a time and gives one response with the four bar levels. A note
// event first finds the frequency with a bit-serial divider, one quotient bit
// per cycle, into FW bits, the width of REF_CLOCK_HZ*256 (35 bits by default);
// then each bar passes through setup, a 6x24 multiply and a six-step level
// divider, or only setup and the multiply when the tone lies outside its band,
// and all bars then decay. A decay tick only decays the bars, and a rest goes
// straight to completion.
// A finished response waits in an output register, so the next request is
// taken while it is still pending; completion only waits when that register
// still holds an unaccepted response.
// Depends on tbbm_pkg, tbbm_freq_div, tbbm_level_div and the defines header.
`include "tone_band_bar_meter_defines.svh"

module tone_band_bar_meter #(
   parameter int unsigned REF_CLOCK_HZ = 125000000
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic                              req_command,
   input  logic [tbbm_pkg::PER_W-1:0]        req_tone_period,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic [tbbm_pkg::LVL_W-1:0]        rsp_bar_level_0,
   output logic [tbbm_pkg::LVL_W-1:0]        rsp_bar_level_1,
   output logic [tbbm_pkg::LVL_W-1:0]        rsp_bar_level_2,
   output logic [tbbm_pkg::LVL_W-1:0]        rsp_bar_level_3,
   input  logic                              csr_write,
   input  logic [tbbm_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [tbbm_pkg::CSR_DATA_W-1:0]   csr_data
);

   localparam longint unsigned DIVIDEND = 64'(REF_CLOCK_HZ) << 8;
   localparam int FW    = $clog2(DIVIDEND + 1);
   localparam int TH_W  = tbbm_pkg::CTR_W + 2 + 8;
   localparam int CMP_W = (FW > TH_W) ? FW : TH_W;
   localparam int CW    = tbbm_pkg::CTR_W;
   localparam int LW    = tbbm_pkg::LVL_W;
   localparam int NB_W  = tbbm_pkg::NB_W;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SCALE,
      ST_FDIV_GO,
      ST_FDIV_WAIT,
      ST_BAR_SETUP,
      ST_BAR_MUL,
      ST_LDIV_GO,
      ST_LDIV_WAIT,
      ST_BAR_UPDATE,
      ST_DECAY,
      ST_DONE
   } state_type;

   state_type state_ff, state_in;

   logic [tbbm_pkg::DIV_W-1:0] clock_divider_ff;
   logic [CW-1:0]              center_0_ff, center_1_ff, center_2_ff, center_3_ff;
   logic [tbbm_pkg::FS_W-1:0]  full_scale_ff;

   logic [LW-1:0] bar_ff [tbbm_pkg::BAR_CNT];
   logic [LW-1:0] bar_in [tbbm_pkg::BAR_CNT];
   logic [LW-1:0] rsp_lvl_ff [tbbm_pkg::BAR_CNT];
   logic [LW-1:0] rsp_lvl_in [tbbm_pkg::BAR_CNT];
   logic          rsp_valid_ff, rsp_valid_in;

   logic [tbbm_pkg::PER_W-1:0]   per_ff, per_in;
   logic [tbbm_pkg::DEN_W-1:0]   fden_ff, fden_in;
   logic [tbbm_pkg::BAR_IDX_W-1:0] idx_ff, idx_in;
   logic [NB_W-1:0]              num_ff, num_in;
   logic [NB_W-1:0]              den_ff, den_in;
   logic                         hit_ff, hit_in;
   logic [tbbm_pkg::PROD_W-1:0]  prod_ff, prod_in;
   logic [LW-1:0]                lvl_ff, lvl_in;

   logic [tbbm_pkg::DIV_W-1:0] div_eff;
   logic [FW-1:0]              freq;
   logic                       fdiv_done;
   logic [LW-1:0]              lvl_q;
   logic                       lvl_done;

   // band edges of the selected bar
   logic [CW+1:0]   edge_l, edge_c, edge_r;
   logic            r_neg;
   logic [CW+2:0]   r3_wide;
   logic [CMP_W-1:0] f_ext, th_l, th_c, th_r;
   logic            rise, fall;
   logic [CMP_W-1:0] rise_num, rise_den, fall_num, fall_den;

   assign div_eff = (clock_divider_ff == '0) ? tbbm_pkg::DIV_W'(1) : clock_divider_ff;

   tbbm_freq_div #(
      .REF_CLOCK_HZ(REF_CLOCK_HZ)
   ) u_freq_div (
      .clock   (clock),
      .reset   (reset),
      .start   (state_ff == ST_FDIV_GO),
      .divisor (fden_ff),
      .quotient(freq),
      .done    (fdiv_done)
   );

   tbbm_level_div u_level_div (
      .clock  (clock),
      .reset  (reset),
      .start  (state_ff == ST_LDIV_GO),
      .product(prod_ff),
      .den    (den_ff),
      .level  (lvl_q),
      .done   (lvl_done)
   );

   // bar 3 falls to twice its centre minus the previous centre
   assign r3_wide = {2'b0, center_3_ff, 1'b0} - {3'b0, center_2_ff};

   always_comb begin
      edge_l = '0;
      edge_c = '0;
      edge_r = '0;
      r_neg  = 1'b0;
      unique case (idx_ff)
         2'd0: begin
            edge_c = {2'b0, center_0_ff};
            edge_r = {2'b0, center_1_ff};
         end
         2'd1: begin
            edge_l = {2'b0, center_0_ff};
            edge_c = {2'b0, center_1_ff};
            edge_r = {2'b0, center_2_ff};
         end
         2'd2: begin
            edge_l = {2'b0, center_1_ff};
            edge_c = {2'b0, center_2_ff};
            edge_r = {2'b0, center_3_ff};
         end
         default: begin
            edge_l = {2'b0, center_2_ff};
            edge_c = {2'b0, center_3_ff};
            edge_r = r3_wide[CW+1:0];
            r_neg  = r3_wide[CW+2];
         end
      endcase
   end

   assign f_ext = CMP_W'(freq);
   assign th_l  = CMP_W'({edge_l, 8'b0});
   assign th_c  = CMP_W'({edge_c, 8'b0});
   assign th_r  = CMP_W'({edge_r, 8'b0});
   assign rise  = (f_ext >= th_l) && (f_ext <= th_c);
   assign fall  = !r_neg && (f_ext > th_c) && (f_ext <= th_r);
   assign rise_num = f_ext - th_l;
   assign rise_den = th_c - th_l;
   assign fall_num = th_r - f_ext;
   assign fall_den = th_r - th_c;

   always_comb begin
      state_in     = state_ff;
      bar_in       = bar_ff;
      rsp_lvl_in   = rsp_lvl_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      per_in       = per_ff;
      fden_in      = fden_ff;
      idx_in       = idx_ff;
      num_in       = num_ff;
      den_in       = den_ff;
      hit_in       = hit_ff;
      prod_in      = prod_ff;
      lvl_in       = lvl_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               per_in = req_tone_period;
               if (req_command) begin
                  state_in = ST_DECAY;
               end else if (req_tone_period == '0) begin
                  state_in = ST_DONE;
               end else begin
                  state_in = ST_SCALE;
               end
            end
         end
         ST_SCALE: begin
            fden_in  = {{tbbm_pkg::PER_W{1'b0}}, div_eff} * {{tbbm_pkg::DIV_W{1'b0}}, per_ff};
            state_in = ST_FDIV_GO;
         end
         ST_FDIV_GO: begin
            state_in = ST_FDIV_WAIT;
         end
         ST_FDIV_WAIT: begin
            if (fdiv_done) begin
               idx_in   = '0;
               state_in = ST_BAR_SETUP;
            end
         end
         ST_BAR_SETUP: begin
            num_in   = rise ? rise_num[NB_W-1:0] : fall_num[NB_W-1:0];
            den_in   = rise ? rise_den[NB_W-1:0] : fall_den[NB_W-1:0];
            // a zero-width rising edge gives no level
            hit_in   = rise ? (rise_den != '0) : fall;
            state_in = ST_BAR_MUL;
         end
         ST_BAR_MUL: begin
            prod_in = {{NB_W{1'b0}}, full_scale_ff} * {{tbbm_pkg::FS_W{1'b0}}, num_ff};
            lvl_in  = '0;
            state_in = hit_ff ? ST_LDIV_GO : ST_BAR_UPDATE;
         end
         ST_LDIV_GO: begin
            state_in = ST_LDIV_WAIT;
         end
         ST_LDIV_WAIT: begin
            if (lvl_done) begin
               lvl_in   = lvl_q;
               state_in = ST_BAR_UPDATE;
            end
         end
         ST_BAR_UPDATE: begin
            // peak hold
            if (lvl_ff > bar_ff[idx_ff]) begin
               bar_in[idx_ff] = lvl_ff;
            end
            if (idx_ff == tbbm_pkg::BAR_IDX_W'(tbbm_pkg::BAR_CNT - 1)) begin
               state_in = ST_DECAY;
            end else begin
               idx_in   = idx_ff + 1'b1;
               state_in = ST_BAR_SETUP;
            end
         end
         ST_DECAY: begin
            for (int i = 0; i < tbbm_pkg::BAR_CNT; i++) begin
               bar_in[i] = tbbm_pkg::decay_level(bar_ff[i]);
            end
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_lvl_in   = bar_ff;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      rsp_lvl_ff <= rsp_lvl_in;
      per_ff     <= per_in;
      fden_ff    <= fden_in;
      idx_ff     <= idx_in;
      num_ff     <= num_in;
      den_ff     <= den_in;
      hit_ff     <= hit_in;
      prod_ff    <= prod_in;
      lvl_ff     <= lvl_in;
      if (reset) begin
         state_ff         <= ST_IDLE;
         rsp_valid_ff     <= 1'b0;
         bar_ff           <= '{default: '0};
         clock_divider_ff <= tbbm_pkg::RST_CLOCK_DIVIDER;
         center_0_ff      <= tbbm_pkg::RST_CENTER_0;
         center_1_ff      <= tbbm_pkg::RST_CENTER_1;
         center_2_ff      <= tbbm_pkg::RST_CENTER_2;
         center_3_ff      <= tbbm_pkg::RST_CENTER_3;
         full_scale_ff    <= tbbm_pkg::RST_FULL_SCALE;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         bar_ff       <= bar_in;
         if (csr_write) begin
            unique case (csr_index)
               tbbm_pkg::CSR_CLOCK_DIVIDER: clock_divider_ff <= csr_data[tbbm_pkg::DIV_W-1:0];
               tbbm_pkg::CSR_CENTER_0:      center_0_ff      <= csr_data[CW-1:0];
               tbbm_pkg::CSR_CENTER_1:      center_1_ff      <= csr_data[CW-1:0];
               tbbm_pkg::CSR_CENTER_2:      center_2_ff      <= csr_data[CW-1:0];
               tbbm_pkg::CSR_CENTER_3:      center_3_ff      <= csr_data[CW-1:0];
               tbbm_pkg::CSR_FULL_SCALE:    full_scale_ff    <= csr_data[tbbm_pkg::FS_W-1:0];
               default: begin
               end
            endcase
         end
      end
   end

   assign req_stall       = (state_ff != ST_IDLE);
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_bar_level_0 = rsp_lvl_ff[0];
   assign rsp_bar_level_1 = rsp_lvl_ff[1];
   assign rsp_bar_level_2 = rsp_lvl_ff[2];
   assign rsp_bar_level_3 = rsp_lvl_ff[3];

   `TBBM_ASSERT_SAME(a_level_in_scale, clock, reset, lvl_done, lvl_q <= full_scale_ff, "bar level above full scale")
   `TBBM_ASSERT_NEXT(a_rsp_from_done, clock, reset, state_ff == ST_DONE && !(rsp_valid_ff && rsp_stall), rsp_valid_ff && state_ff == ST_IDLE, "response not loaded on completion")
   `TBBM_ASSERT_NEXT(a_decay_lowers, clock, reset, state_ff == ST_DECAY, bar_ff[0] <= $past(bar_ff[0]) && bar_ff[3] <= $past(bar_ff[3]), "decay raised a bar")

endmodule
